>>> design/quaternion_to_euler_angles_defines.svh
// assertion macros for the quaternion to euler angle converter
// used by the top level only; needs nothing else
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("implication check failed");
`define Q2E_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`else
`define Q2E_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define Q2E_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

>>> design/q2e_pkg.sv
// types, constants and per-stage arithmetic of the quaternion to euler angle converter
// no dependencies; used by quaternion_to_euler_angles
`default_nettype none

package q2e_pkg;

    localparam int COMP_W      = 16;
    localparam int FRAC_W      = COMP_W - 2;
    localparam int PROD_W      = 2 * COMP_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int T_W         = COMP_W + 2;
    localparam int S_W         = COMP_W;
    localparam int N_W         = 2 * FRAC_W + 1;
    localparam int R_W         = N_W + 2;
    localparam int C_W         = FRAC_W + 1;
    localparam int XY_W        = T_W + 4;
    localparam int Z_W         = 34;
    localparam int ANG_W       = 16;
    localparam int RND_W       = Z_W - ANG_W;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS  = FRAC_W + 1;
    localparam int SQRT_PER    = 3;
    localparam int SQRT_STAGES = (SQRT_STEPS + SQRT_PER - 1) / SQRT_PER;

    localparam logic signed [COMP_W-1:0] ONE_F = COMP_W'(1) << FRAC_W;
    localparam logic signed [SUM_W-1:0]  ONE_2F = SUM_W'(1) << (2 * FRAC_W);
    localparam logic signed [Z_W-1:0]    ANGLE_QUARTER = Z_W'(1) << 30;
    localparam logic signed [Z_W-1:0]    ROUND_HALF = Z_W'(1) << 15;
    localparam logic signed [RND_W-1:0]  PITCH_LIMIT = RND_W'(16384);

    typedef struct packed {
        logic signed [T_W-1:0] t0;
        logic signed [T_W-1:0] t1;
        logic signed [T_W-1:0] t3;
        logic signed [T_W-1:0] t4;
        logic signed [S_W-1:0] s;
    } terms_t;

    typedef struct packed {
        terms_t          tm;
        logic [N_W-1:0]  n;
        logic [R_W-1:0]  res;
    } root_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } lane_t;

    typedef struct packed {
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
        logic  pole;
        logic  s_pos;
    } cord_t;

    // saturate a component to plus or minus one
    function automatic logic signed [COMP_W-1:0] clamp_comp(logic signed [COMP_W-1:0] v);
        logic signed [COMP_W-1:0] r;
        r = v;
        if (v > ONE_F)
            r = ONE_F;
        if (v < -ONE_F)
            r = -ONE_F;
        return r;
    endfunction

    // arctangent of two to the minus i, 2^31 is pi
    function automatic logic signed [Z_W-1:0] atan_entry(int i);
        logic signed [Z_W-1:0] r;
        unique case (i)
            0:  r = Z_W'(536870912);
            1:  r = Z_W'(316933406);
            2:  r = Z_W'(167458907);
            3:  r = Z_W'(85004756);
            4:  r = Z_W'(42667331);
            5:  r = Z_W'(21354465);
            6:  r = Z_W'(10679838);
            7:  r = Z_W'(5340245);
            8:  r = Z_W'(2670163);
            9:  r = Z_W'(1335087);
            10: r = Z_W'(667544);
            11: r = Z_W'(333772);
            12: r = Z_W'(166886);
            13: r = Z_W'(83443);
            14: r = Z_W'(41722);
            15: r = Z_W'(20861);
            16: r = Z_W'(10430);
            17: r = Z_W'(5215);
            18: r = Z_W'(2608);
            19: r = Z_W'(1304);
            20: r = Z_W'(652);
            21: r = Z_W'(326);
            22: r = Z_W'(163);
            23: r = Z_W'(81);
            default: r = '0;
        endcase
        return r;
    endfunction

    // a few restoring square root steps, starting at overall step j0
    function automatic root_t root_steps(root_t a, int j0);
        root_t           r;
        logic [R_W-1:0]  bit_v;
        logic [R_W-1:0]  trial;
        int              k;
        r = a;
        for (int t = 0; t < SQRT_PER; t++) begin
            if (j0 + t < SQRT_STEPS) begin
                k = SQRT_STEPS - 1 - (j0 + t);
                bit_v = R_W'(1) << (2 * k);
                trial = r.res + bit_v;
                if (R_W'(r.n) >= trial) begin
                    r.n   = N_W'(R_W'(r.n) - trial);
                    r.res = (r.res >> 1) + bit_v;
                end
                else begin
                    r.res = r.res >> 1;
                end
            end
        end
        return r;
    endfunction

    // fold the left half plane into the right half plane
    function automatic lane_t pre_rotate(logic signed [XY_W-1:0] y, logic signed [XY_W-1:0] x);
        lane_t r;
        r.x    = x;
        r.y    = y;
        r.z    = '0;
        r.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            if (y >= 0) begin
                r.x = y;
                r.y = -x;
                r.z = ANGLE_QUARTER;
            end
            else begin
                r.x = -y;
                r.y = x;
                r.z = -ANGLE_QUARTER;
            end
        end
        return r;
    endfunction

    // one vectoring micro-rotation
    function automatic lane_t cordic_iter(lane_t a, int i);
        lane_t                  r;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        r  = a;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (a.y > 0) begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + atan_entry(i);
        end
        else begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - atan_entry(i);
        end
        return r;
    endfunction

    // round a wide angle to nearest, half up, keeping the upper bits
    function automatic logic signed [RND_W-1:0] round_angle(lane_t a);
        logic signed [Z_W-1:0] t;
        t = (a.z + ROUND_HALF) >>> ANG_W;
        return a.zero ? '0 : RND_W'(t);
    endfunction

endpackage

`default_nettype wire

>>> design/quaternion_to_euler_angles.sv
// quaternion to zyx euler angles: product terms, square root and three cordic lanes
// depends on q2e_pkg and quaternion_to_euler_angles_defines.svh
`default_nettype none
`include "quaternion_to_euler_angles_defines.svh"

// Takes one unit quaternion (16384 = 1.0, components saturated to +-1.0) per clock
// and returns roll, pitch and yaw as 16-bit binary angles (32768 = pi), ZYX order.
// Fully pipelined: a new quaternion is accepted every cycle while the output is not held,
// and each result passes three stages of products and terms, five stages of square
// root, one folding stage, one stage per cordic micro-rotation and one rounding
// stage. The whole pipeline advances together; when the output is held
// every stage holds, so back-pressure stalls input transfers without losing items.
module quaternion_to_euler_angles
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              quat_valid,
    output      logic                              quat_ready,
    input  wire logic signed [q2e_pkg::COMP_W-1:0] quat_x,
    input  wire logic signed [q2e_pkg::COMP_W-1:0] quat_y,
    input  wire logic signed [q2e_pkg::COMP_W-1:0] quat_z,
    input  wire logic signed [q2e_pkg::COMP_W-1:0] quat_w,
    output      logic                              angle_valid,
    input  wire logic                              angle_ready,
    output      logic signed [q2e_pkg::ANG_W-1:0]  roll_angle,
    output      logic signed [q2e_pkg::ANG_W-1:0]  pitch_angle,
    output      logic signed [q2e_pkg::ANG_W-1:0]  yaw_angle
);

    localparam int PW = q2e_pkg::PROD_W;
    localparam int SW = q2e_pkg::SUM_W;
    localparam int NS = q2e_pkg::CORDIC_STEPS;
    localparam int QS = q2e_pkg::SQRT_STAGES;

    logic adv;

    // stage 1: products
    logic                 v1_reg;
    logic signed [PW-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [PW-1:0] p_wy_reg, p_zx_reg, p_wz_reg, p_xy_reg;
    logic signed [PW-1:0] ex, ey, ez, ew;

    // stage 2 and 3: terms, then radicand
    logic                    v2_reg, v3_reg;
    q2e_pkg::terms_t         tm2_next, tm2_reg, tm3_reg;
    logic [q2e_pkg::N_W-1:0] n3_next, n3_reg;

    // square root stages
    logic                  sq_vld_reg [QS];
    q2e_pkg::root_t        sq_reg     [QS];
    q2e_pkg::root_t        sq_in      [QS];

    // cordic stages, index 0 is the folded input
    logic                  cr_vld_reg [NS+1];
    q2e_pkg::cord_t        cr_reg     [NS+1];
    q2e_pkg::cord_t        cr0_next;

    // output register
    logic                  out_vld_reg;
    logic signed [q2e_pkg::ANG_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [q2e_pkg::ANG_W-1:0] roll_next, pitch_next, yaw_next;

    assign adv        = !out_vld_reg || angle_ready;
    assign quat_ready = adv;

    // clamp and sign-extend components
    always_comb
    begin
        ex = PW'(q2e_pkg::clamp_comp(quat_x));
        ey = PW'(q2e_pkg::clamp_comp(quat_y));
        ez = PW'(q2e_pkg::clamp_comp(quat_z));
        ew = PW'(q2e_pkg::clamp_comp(quat_w));
    end

    // product terms, shifted to the component scale
    always_comb
    begin
        logic signed [SW-1:0] a0, a1, a2, a3, a4;
        a0 = (SW'(p_wx_reg) + SW'(p_yz_reg)) <<< 1;
        a1 = q2e_pkg::ONE_2F - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
        a2 = (SW'(p_wy_reg) - SW'(p_zx_reg)) <<< 1;
        a3 = (SW'(p_wz_reg) + SW'(p_xy_reg)) <<< 1;
        a4 = q2e_pkg::ONE_2F - ((SW'(p_yy_reg) + SW'(p_zz_reg)) <<< 1);
        if (a2 > q2e_pkg::ONE_2F)
            a2 = q2e_pkg::ONE_2F;
        if (a2 < -q2e_pkg::ONE_2F)
            a2 = -q2e_pkg::ONE_2F;
        tm2_next.t0 = q2e_pkg::T_W'(a0 >>> q2e_pkg::FRAC_W);
        tm2_next.t1 = q2e_pkg::T_W'(a1 >>> q2e_pkg::FRAC_W);
        tm2_next.t3 = q2e_pkg::T_W'(a3 >>> q2e_pkg::FRAC_W);
        tm2_next.t4 = q2e_pkg::T_W'(a4 >>> q2e_pkg::FRAC_W);
        tm2_next.s  = q2e_pkg::S_W'(a2 >>> q2e_pkg::FRAC_W);
    end

    // radicand one minus s squared
    always_comb
    begin
        logic signed [PW-1:0] ss;
        ss      = PW'(tm2_reg.s) * PW'(tm2_reg.s);
        n3_next = q2e_pkg::N_W'(q2e_pkg::ONE_2F - SW'(ss));
    end

    // square root stage inputs
    always_comb
    begin
        for (int k = 0; k < QS; k++) begin
            if (k == 0) begin
                sq_in[k].tm  = tm3_reg;
                sq_in[k].n   = n3_reg;
                sq_in[k].res = '0;
            end
            else begin
                sq_in[k] = sq_reg[k-1];
            end
        end
    end

    // fold all three vectors into the right half plane
    always_comb
    begin
        q2e_pkg::root_t                  rt;
        logic [q2e_pkg::C_W-1:0]         c;
        rt = sq_reg[QS-1];
        c  = rt.res[q2e_pkg::C_W-1:0];
        cr0_next.roll  = q2e_pkg::pre_rotate(q2e_pkg::XY_W'(rt.tm.t0),
                                             q2e_pkg::XY_W'(rt.tm.t1));
        cr0_next.yaw   = q2e_pkg::pre_rotate(q2e_pkg::XY_W'(rt.tm.t3),
                                             q2e_pkg::XY_W'(rt.tm.t4));
        cr0_next.pitch = q2e_pkg::pre_rotate(q2e_pkg::XY_W'(rt.tm.s),
                                             q2e_pkg::XY_W'($signed({1'b0, c})));
        cr0_next.pole  = (c == '0);
        cr0_next.s_pos = (rt.tm.s > 0);
    end

    // rounding and pitch limits
    always_comb
    begin
        logic signed [q2e_pkg::RND_W-1:0] rp;
        q2e_pkg::cord_t                   f;
        f  = cr_reg[NS];
        rp = q2e_pkg::round_angle(f.pitch);
        if (rp > q2e_pkg::PITCH_LIMIT)
            rp = q2e_pkg::PITCH_LIMIT;
        if (rp < -q2e_pkg::PITCH_LIMIT)
            rp = -q2e_pkg::PITCH_LIMIT;
        if (f.pole)
            rp = f.s_pos ? q2e_pkg::PITCH_LIMIT : -q2e_pkg::PITCH_LIMIT;
        roll_next  = q2e_pkg::ANG_W'(q2e_pkg::round_angle(f.roll));
        yaw_next   = q2e_pkg::ANG_W'(q2e_pkg::round_angle(f.yaw));
        pitch_next = q2e_pkg::ANG_W'(rp);
    end

    // front stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            cr_vld_reg[0] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv) begin
            v1_reg      <= quat_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            cr_vld_reg[0] <= sq_vld_reg[QS-1];
            out_vld_reg <= cr_vld_reg[NS];
        end
    end

    // front stage payload
    always_ff @(posedge clk)
    begin
        if (adv) begin
            p_wx_reg <= ew * ex;
            p_yz_reg <= ey * ez;
            p_xx_reg <= ex * ex;
            p_yy_reg <= ey * ey;
            p_zz_reg <= ez * ez;
            p_wy_reg <= ew * ey;
            p_zx_reg <= ez * ex;
            p_wz_reg <= ew * ez;
            p_xy_reg <= ex * ey;
            tm2_reg  <= tm2_next;
            tm3_reg  <= tm2_reg;
            n3_reg   <= n3_next;
            cr_reg[0] <= cr0_next;
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    // square root pipeline, a few result bits per stage
    for (genvar k = 0; k < QS; k++) begin : g_sqrt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k] <= 1'b0;
            else if (adv)
                sq_vld_reg[k] <= (k == 0) ? v3_reg : sq_vld_reg[(k == 0) ? 0 : k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                sq_reg[k] <= q2e_pkg::root_steps(sq_in[k], k * q2e_pkg::SQRT_PER);
        end
    end

    // cordic pipeline, one micro-rotation per stage on all three lanes
    for (genvar i = 0; i < NS; i++) begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cr_vld_reg[i+1] <= 1'b0;
            else if (adv)
                cr_vld_reg[i+1] <= cr_vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv) begin
                cr_reg[i+1].roll  <= q2e_pkg::cordic_iter(cr_reg[i].roll, i);
                cr_reg[i+1].pitch <= q2e_pkg::cordic_iter(cr_reg[i].pitch, i);
                cr_reg[i+1].yaw   <= q2e_pkg::cordic_iter(cr_reg[i].yaw, i);
                cr_reg[i+1].pole  <= cr_reg[i].pole;
                cr_reg[i+1].s_pos <= cr_reg[i].s_pos;
            end
        end
    end

    assign angle_valid = out_vld_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

    // pitch never leaves plus or minus a quarter turn
    `Q2E_ASSERT_IMPL(a_pitch_range, clk, rst_n, angle_valid,
        (pitch_angle <= 16'sd16384) && (pitch_angle >= -16'sd16384))
    // an item at a pole comes out at exactly a quarter turn
    `Q2E_ASSERT_NEXT(a_pitch_pole, clk, rst_n, adv && cr_vld_reg[NS] && cr_reg[NS].pole,
        (pitch_angle == 16'sd16384) || (pitch_angle == -16'sd16384))
    // a zero roll vector gives a zero roll angle
    `Q2E_ASSERT_NEXT(a_roll_zero, clk, rst_n, adv && cr_vld_reg[NS] && cr_reg[NS].roll.zero,
        roll_angle == '0)

endmodule

`default_nettype wire
